FILE: hw/rtl/bfdr_pkg.sv
// Shared types, widths and status codes for the bounded FIFO with duplicate reject.
package bfdr_pkg;

   localparam int DEPTH    = 16;
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int NAME_W   = 64;
   localparam int TIME_W   = 16;
   localparam int STATUS_W = 3;
   localparam int CAP_W    = 5;
   localparam int OCC_W    = 5;
   localparam int CAP_RESET = 16;

   // Request and response tdata layout, lowest bits first.
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;
   localparam int OCC_LSB    = NAME_W + TIME_W;

   typedef enum logic [STATUS_W-1:0] {
      ST_PUSHED    = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_POPPED    = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } mem_req_type;

   // Slot that lies a given number of places after base, wrapping at DEPTH.
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/bfdr_store.sv
// Entry memory: one write port and one registered read port.
module bfdr_store (
   input  logic                 clock,
   input  bfdr_pkg::mem_req_type mem_req,
   output bfdr_pkg::entry_type  rd_data
);

   bfdr_pkg::entry_type mem [bfdr_pkg::DEPTH];
   bfdr_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bfdr_match.sv
// Shared compare unit: flags a stored entry whose name or time equals the key.
module bfdr_match (
   input  bfdr_pkg::entry_type key,
   input  bfdr_pkg::entry_type candidate,
   output logic                hit
);

   logic name_eq;
   logic time_eq;

   assign name_eq = (key.name == candidate.name);
   assign time_eq = (key.stamp == candidate.stamp);
   assign hit     = name_eq | time_eq;

endmodule

FILE: hw/rtl/bfdr_ctrl.sv
// Sequencer: scans stored entries one at a time, updates pointers, holds the response.
module bfdr_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_mode,
   input  bfdr_pkg::entry_type             req_entry,
   output logic                            req_ready,
   input  logic [bfdr_pkg::CAP_W-1:0]      capacity,
   output bfdr_pkg::mem_req_type           mem_req,
   input  bfdr_pkg::entry_type             rd_data,
   output bfdr_pkg::entry_type             key,
   input  logic                            hit,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bfdr_pkg::status_type            rsp_status,
   output bfdr_pkg::entry_type             rsp_entry,
   output logic [bfdr_pkg::OCC_W-1:0]      rsp_occ
);

   localparam int CMP_W = ((bfdr_pkg::CNT_W > bfdr_pkg::CAP_W) ?
                           bfdr_pkg::CNT_W : bfdr_pkg::CAP_W) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_WRITE,
      S_POP_RD,
      S_POP_DATA,
      S_DONE
   } state_type;

   state_type                     state_ff,      state_in;
   logic [bfdr_pkg::PTR_W-1:0]    head_ff,       head_in;
   logic [bfdr_pkg::CNT_W-1:0]    count_ff,      count_in;
   logic [bfdr_pkg::CNT_W-1:0]    scan_ff,       scan_in;
   bfdr_pkg::entry_type           key_ff,        key_in;
   bfdr_pkg::status_type          res_status_ff, res_status_in;
   bfdr_pkg::entry_type           res_entry_ff,  res_entry_in;
   logic                          rsp_valid_ff,  rsp_valid_in;
   bfdr_pkg::status_type          rsp_status_ff, rsp_status_in;
   bfdr_pkg::entry_type           rsp_entry_ff,  rsp_entry_in;
   logic [bfdr_pkg::OCC_W-1:0]    rsp_occ_ff,    rsp_occ_in;
   logic                          full;

   // Count is never above DEPTH, so this is count >= min(capacity, DEPTH).
   assign full = (CMP_W'(count_ff) >= CMP_W'(capacity)) ||
                 (count_ff == bfdr_pkg::CNT_W'(bfdr_pkg::DEPTH));

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in       = req_entry;
               res_entry_in = '0;
               scan_in      = '0;
               if (req_mode) begin
                  if (count_ff == '0) begin
                     res_status_in = bfdr_pkg::ST_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_POP_RD;
                  end
               end else if (count_ff == '0) begin
                  if (full) begin
                     res_status_in = bfdr_pkg::ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_WRITE;
                  end
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = bfdr_pkg::slot_of(head_ff, scan_ff);
            scan_in         = scan_ff + bfdr_pkg::CNT_W'(1);
            state_in        = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            priority if (hit) begin
               res_status_in = bfdr_pkg::ST_DUPLICATE;
               state_in      = S_DONE;
            end else if (scan_ff != count_ff) begin
               state_in = S_SCAN_RD;
            end else if (full) begin
               res_status_in = bfdr_pkg::ST_FULL;
               state_in      = S_DONE;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = bfdr_pkg::slot_of(head_ff, count_ff);
            mem_req.wr_data = key_ff;
            count_in        = count_ff + bfdr_pkg::CNT_W'(1);
            res_status_in   = bfdr_pkg::ST_PUSHED;
            state_in        = S_DONE;
         end
         S_POP_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = head_ff;
            state_in        = S_POP_DATA;
         end
         S_POP_DATA: begin
            res_entry_in  = rd_data;
            head_in       = bfdr_pkg::slot_of(head_ff, bfdr_pkg::CNT_W'(1));
            count_in      = count_ff - bfdr_pkg::CNT_W'(1);
            res_status_in = bfdr_pkg::ST_POPPED;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_occ_in    = bfdr_pkg::OCC_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff       <= scan_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign key        = key_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_occ    = rsp_occ_ff;

endmodule

FILE: hw/rtl/bounded_fifo_with_duplicate_reject.sv
// Top level of the bounded FIFO with duplicate reject.
// A pop reads the oldest slot and then takes its data; an empty pop skips the memory read.
// A push scans the n stored entries through one comparator and one memory read port,
// one read and one compare per entry, and writes only after a clean scan.
// One request is in work at a time; the next is accepted the cycle after the response loads.
// Reset empties the store, sets capacity to 16 and clears the response valid; memory is not cleared.
module bounded_fifo_with_duplicate_reject (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bfdr_pkg::REQ_DATA_W-1:0]     req_tdata,  // entry_name[63:0], entry_time[79:64]
   input  logic                                req_tuser,  // mode: 0 push, 1 pop
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bfdr_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // popped_name[63:0],
                                                           // popped_time[79:64],
                                                           // occupancy[84:80], zero fill
   output logic [bfdr_pkg::STATUS_W-1:0]       rsp_tuser,  // status[2:0]
   // Capacity register write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bfdr_pkg::CAP_W-1:0]          csr_wdata
);

   logic [bfdr_pkg::CAP_W-1:0] capacity_ff;
   bfdr_pkg::entry_type        req_entry;
   bfdr_pkg::mem_req_type      mem_req;
   bfdr_pkg::entry_type        rd_data;
   bfdr_pkg::entry_type        key;
   logic                       hit;
   bfdr_pkg::status_type       rsp_status;
   bfdr_pkg::entry_type        rsp_entry;
   logic [bfdr_pkg::OCC_W-1:0] rsp_occ;

   // The capacity register takes a write in any cycle. Writes are to be made only while the
   // block is idle, so a request in work sees one value; the block itself does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bfdr_pkg::CAP_W'(bfdr_pkg::CAP_RESET);
      end else if (csr_valid) begin
         capacity_ff <= csr_wdata;
      end
   end

   // Unpack the request: name in the low bits, time above it.
   assign req_entry.name  = req_tdata[bfdr_pkg::NAME_W-1:0];
   assign req_entry.stamp = req_tdata[bfdr_pkg::NAME_W +: bfdr_pkg::TIME_W];

   // The sequencer walks the stored entries from the oldest, reading one slot per
   // pass and handing it with the pushed key to the compare unit. A match ends the
   // scan early; a clean scan is followed by the capacity test and, if room remains, the write.
   bfdr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_mode   (req_tuser),
      .req_entry  (req_entry),
      .req_ready  (req_tready),
      .capacity   (capacity_ff),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .key        (key),
      .hit        (hit),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_entry  (rsp_entry),
      .rsp_occ    (rsp_occ)
   );

   bfdr_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   bfdr_match u_match (
      .key       (key),
      .candidate (rd_data),
      .hit       (hit)
   );

   // Pack the response; the popped fields are zero for anything but a pop.
   assign rsp_tdata = {{(bfdr_pkg::RSP_DATA_W - bfdr_pkg::OCC_LSB - bfdr_pkg::OCC_W){1'b0}},
                       rsp_occ, rsp_entry.stamp, rsp_entry.name};
   assign rsp_tuser = rsp_status;

endmodule

FILE: hw/rtl/bfdr_checker.sv
// Port-level assertions for the bounded FIFO with duplicate reject, bound to the top level.
module bfdr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bfdr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [bfdr_pkg::STATUS_W-1:0]   rsp_tuser
);

   logic [bfdr_pkg::OCC_W-1:0] occ;

   assign occ = rsp_tdata[bfdr_pkg::OCC_LSB +: bfdr_pkg::OCC_W];

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // One request at a time: after acceptance the block is busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Only a pop carries entry data.
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != bfdr_pkg::ST_POPPED) |->
         rsp_tdata[bfdr_pkg::OCC_LSB-1:0] == '0)
      else $error("entry data on a response that is not a pop");

   // An empty pop reports zero occupancy, a successful push a nonzero one.
   a_occ_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser != bfdr_pkg::ST_EMPTY) || (occ == '0)) &&
                     ((rsp_tuser != bfdr_pkg::ST_PUSHED) || (occ != '0)))
      else $error("occupancy disagrees with status");

   // Occupancy never exceeds the built depth.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ <= bfdr_pkg::OCC_W'(bfdr_pkg::DEPTH))
      else $error("occupancy above depth");

endmodule

bind bounded_fifo_with_duplicate_reject bfdr_checker u_bfdr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/sv/bounded_fifo_with_duplicate_reject_test.sv
// Self-checking stream testbench for the bounded FIFO with duplicate reject.
`timescale 1ns / 100ps

module bounded_fifo_with_duplicate_reject_test;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 2 * bfdr_pkg::DEPTH + 8;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_profile_type;

   typedef struct {
      bfdr_pkg::status_type        status;
      logic [bfdr_pkg::NAME_W-1:0] name;
      logic [bfdr_pkg::TIME_W-1:0] stamp;
      logic [bfdr_pkg::OCC_W-1:0]  occupancy;
   } outcome_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [bfdr_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [bfdr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [bfdr_pkg::STATUS_W-1:0]   rsp_tuser;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [bfdr_pkg::CAP_W-1:0]      csr_wdata = '0;

   // Mirror of the depot: contents, oldest slot, fill level and capacity setting.
   logic [bfdr_pkg::NAME_W-1:0] depot_names [bfdr_pkg::DEPTH];
   logic [bfdr_pkg::TIME_W-1:0] depot_times [bfdr_pkg::DEPTH];
   int                          oldest_slot = 0;
   int                          held_count = 0;
   int                          capacity_setting = bfdr_pkg::CAP_RESET;

   outcome_type pending_outcomes [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_cycles = 0;

   bounded_fifo_with_duplicate_reject DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Mirror slot that lies offset places after the oldest entry.
   function automatic logic [bfdr_pkg::PTR_W-1:0] slot_at(input int offset);
      return bfdr_pkg::PTR_W'((oldest_slot + offset) % bfdr_pkg::DEPTH);
   endfunction

   // Works out the response to one accepted request and updates the mirror.
   function automatic outcome_type apply_request(input bit pop,
                                                 input logic [bfdr_pkg::NAME_W-1:0] nm,
                                                 input logic [bfdr_pkg::TIME_W-1:0] tm);
      outcome_type                  result;
      int                           limit;
      logic [bfdr_pkg::PTR_W-1:0]   slot;
      bit                           clash;
      result.name  = '0;
      result.stamp = '0;
      limit = (capacity_setting > bfdr_pkg::DEPTH) ? bfdr_pkg::DEPTH : capacity_setting;
      clash = 1'b0;
      if (!pop) begin
         for (int k = 0; k < held_count; k++) begin
            slot = slot_at(k);
            if (depot_names[slot] == nm || depot_times[slot] == tm) clash = 1'b1;
         end
         // A clash wins over a full store.
         if (clash) begin
            result.status = bfdr_pkg::ST_DUPLICATE;
         end else if (held_count >= limit) begin
            result.status = bfdr_pkg::ST_FULL;
         end else begin
            slot = slot_at(held_count);
            depot_names[slot] = nm;
            depot_times[slot] = tm;
            held_count++;
            result.status = bfdr_pkg::ST_PUSHED;
         end
      end else if (held_count == 0) begin
         result.status = bfdr_pkg::ST_EMPTY;
      end else begin
         slot = slot_at(0);
         result.name  = depot_names[slot];
         result.stamp = depot_times[slot];
         oldest_slot  = (oldest_slot + 1) % bfdr_pkg::DEPTH;
         held_count--;
         result.status = bfdr_pkg::ST_POPPED;
      end
      result.occupancy = bfdr_pkg::OCC_W'(held_count);
      return result;
   endfunction

   // Receiver: random stalls, or a long hold-off while hold_cycles runs down.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every accepted response is compared with the oldest outstanding expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response with no request outstanding: status %0d", rsp_tuser);
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[bfdr_pkg::NAME_W-1:0] !== want.name) begin
               $error("popped_name: expected %h, actual %h", want.name,
                      rsp_tdata[bfdr_pkg::NAME_W-1:0]);
               fail_count++;
            end
            if (rsp_tdata[bfdr_pkg::NAME_W +: bfdr_pkg::TIME_W] !== want.stamp) begin
               $error("popped_time: expected %h, actual %h", want.stamp,
                      rsp_tdata[bfdr_pkg::NAME_W +: bfdr_pkg::TIME_W]);
               fail_count++;
            end
            if (rsp_tdata[bfdr_pkg::OCC_LSB +: bfdr_pkg::OCC_W] !== want.occupancy) begin
               $error("occupancy: expected %0d, actual %0d", want.occupancy,
                      rsp_tdata[bfdr_pkg::OCC_LSB +: bfdr_pkg::OCC_W]);
               fail_count++;
            end
         end
      end
   end

   task automatic set_idling(input idle_profile_type profile);
      send_idle_pct  = (profile == IDLE_SENDER) ? 76 : (profile == IDLE_BOTH) ? 11 : 0;
      recv_stall_pct = (profile == IDLE_RECEIVER) ? 76 : (profile == IDLE_BOTH) ? 11 : 0;
   endtask

   // Offers one request after a random gap; valid stays up for a following request.
   task automatic send_request(input bit pop, input logic [bfdr_pkg::NAME_W-1:0] nm,
                               input logic [bfdr_pkg::TIME_W-1:0] tm);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= pop;
      req_tdata  <= {tm, nm};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_outcomes.push_back(apply_request(pop, nm, tm));
   endtask

   task automatic stop_offering();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected response has come back, then a short pause.
   task automatic settle_depot();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [bfdr_pkg::CAP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      capacity_setting = int'(value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Names and times mostly fresh, sometimes taken from a stored entry to force a clash.
   function automatic logic [bfdr_pkg::NAME_W-1:0] choose_name();
      int roll;
      roll = $urandom_range(99);
      if (held_count > 0 && roll < 12)
         return depot_names[slot_at(int'($urandom_range(held_count - 1)))];
      if (roll < 14) return '0;
      if (roll < 16) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [bfdr_pkg::TIME_W-1:0] choose_time();
      int roll;
      roll = $urandom_range(99);
      if (held_count > 0 && roll < 12)
         return depot_times[slot_at(int'($urandom_range(held_count - 1)))];
      if (roll < 14) return '0;
      if (roll < 16) return '1;
      return bfdr_pkg::TIME_W'($urandom_range(65535));
   endfunction

   task automatic send_random(input int push_pct);
      bit                          pop;
      logic [bfdr_pkg::NAME_W-1:0] nm;
      logic [bfdr_pkg::TIME_W-1:0] tm;
      pop = ($urandom_range(99) >= push_pct);
      nm  = choose_name();
      tm  = choose_time();
      send_request(pop, nm, tm);
   endtask

   // Push, pop, clashes on either key, field extremes and popping an empty store.
   task automatic test_basic_operations();
      set_idling(IDLE_NONE);
      send_request(1'b1, '1, '1);
      send_request(1'b0, '0, '0);
      send_request(1'b0, '1, '1);
      send_request(1'b0, '0, 16'h0005);
      send_request(1'b0, 64'h0000_0000_0000_0005, '1);
      send_request(1'b0, 64'h0123_4567_89AB_CDEF, 16'h8000);
      repeat (4) send_request(1'b1, '0, '0);
      stop_offering();
      settle_depot();
   endtask

   // Zero capacity, a clash on a full store, and capacity lowered under the fill level.
   task automatic test_capacity_edges();
      write_capacity(5'd0);
      send_request(1'b0, 64'hA5A5_0000_0000_0001, 16'h0101);
      send_request(1'b1, '0, '0);
      stop_offering();
      settle_depot();
      write_capacity(5'd2);
      send_request(1'b0, 64'hA5A5_0000_0000_0001, 16'h0101);
      send_request(1'b0, 64'hA5A5_0000_0000_0002, 16'h0202);
      send_request(1'b0, 64'hA5A5_0000_0000_0003, 16'h0303);
      send_request(1'b0, 64'hA5A5_0000_0000_0001, 16'h0404);
      stop_offering();
      settle_depot();
      write_capacity(5'd1);
      send_request(1'b0, 64'hA5A5_0000_0000_0003, 16'h0303);
      send_request(1'b1, '0, '0);
      send_request(1'b0, 64'hA5A5_0000_0000_0003, 16'h0303);
      send_request(1'b1, '0, '0);
      send_request(1'b0, 64'hA5A5_0000_0000_0003, 16'h0303);
      send_request(1'b1, '0, '0);
      stop_offering();
      settle_depot();
   endtask

   // Random traffic in alternating fill and drain stretches at one capacity.
   task automatic test_random_traffic(input logic [bfdr_pkg::CAP_W-1:0] capacity,
                                      input idle_profile_type profile, input int count);
      write_capacity(capacity);
      set_idling(profile);
      for (int i = 0; i < count; i++) send_random(((i / 20) % 2 == 0) ? 80 : 30);
      stop_offering();
      settle_depot();
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_receiver_hold_off();
      write_capacity(5'd16);
      set_idling(IDLE_NONE);
      hold_cycles = 300;
      for (int i = 0; i < 60; i++) send_random(70);
      stop_offering();
      settle_depot();
   endtask

   // The sender stops until every response is back, then carries on.
   task automatic test_sender_pause();
      set_idling(IDLE_BOTH);
      for (int i = 0; i < 20; i++) send_random(75);
      stop_offering();
      while (pending_outcomes.size() != 0) @(posedge clock);
      for (int i = 0; i < 15; i++) send_random(25);
      stop_offering();
      settle_depot();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_operations();
      test_capacity_edges();
      test_random_traffic(5'd16, IDLE_NONE, 150);
      test_random_traffic(5'd4, IDLE_SENDER, 150);
      test_random_traffic(5'd31, IDLE_RECEIVER, 150);
      test_random_traffic(5'd0, IDLE_BOTH, 40);
      test_random_traffic(5'd1, IDLE_NONE, 80);
      test_receiver_hold_off();
      test_random_traffic(5'd9, IDLE_NONE, 100);
      test_random_traffic(5'd16, IDLE_BOTH, 150);
      test_sender_pause();

      settle_depot();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d expected responses never arrived", pending_outcomes.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
